>>> rtl/core/pfb_pkg.sv
// Shared types and constants for the byte Playfair cipher.
// No dependencies; imported by pfb_front, pfb_back and playfair_byte_cipher.
package pfb_pkg;

	localparam int BYTE_W     = 8;
	localparam int BYTE_COUNT = 256;

	// operation codes on the request port
	localparam logic [1:0] OP_KEY     = 2'd0;
	localparam logic [1:0] OP_FINAL   = 2'd1;
	localparam logic [1:0] OP_ENCRYPT = 2'd2;

	// result status codes
	localparam logic [1:0] STAT_DONE    = 2'd0;
	localparam logic [1:0] STAT_IGNORED = 2'd1;
	localparam logic [1:0] STAT_REJECT  = 2'd2;

	// decoded request class carried from front to back
	typedef logic [1:0] kind_t;
	localparam kind_t KIND_KEY     = 2'd0;
	localparam kind_t KIND_FINAL   = 2'd1;
	localparam kind_t KIND_ENCRYPT = 2'd2;
	localparam kind_t KIND_BAD     = 2'd3;

	typedef struct packed {
		kind_t             kind;
		logic              key_zero;
		logic [BYTE_W-1:0] byte_a;
		logic [BYTE_W-1:0] byte_b;
	} cmd_t;

	typedef struct packed {
		logic [BYTE_W-1:0] first_out;
		logic [BYTE_W-1:0] second_out;
		logic [1:0]        status;
	} res_t;

endpackage

>>> rtl/core/pfb_front.sv
// Front end: accepts requests, decodes the operation and queues the
// decoded command in a two-entry queue. Depends on pfb_pkg.
module pfb_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  logic [1:0]          operation,
	input  logic [7:0]          first_byte,
	input  logic [7:0]          second_byte,
	output pfb_pkg::cmd_t       cmd,
	output logic                cmd_valid,
	input  logic                cmd_take
);
	import pfb_pkg::*;

	cmd_t       slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	cmd_t       dec;
	logic       wr_en;
	logic       rd_en;

	always_comb begin
		dec.byte_a   = first_byte;
		dec.byte_b   = second_byte;
		dec.key_zero = (first_byte == '0);
		unique case (operation)
			OP_KEY:     dec.kind = KIND_KEY;
			OP_FINAL:   dec.kind = KIND_FINAL;
			OP_ENCRYPT: dec.kind = KIND_ENCRYPT;
			default:    dec.kind = KIND_BAD;
		endcase
	end

	assign full      = (count_q == 2'd2);
	assign cmd_valid = (count_q != 2'd0);
	assign cmd       = slot_q[rd_ptr_q];
	assign wr_en     = push && !full;
	assign rd_en     = cmd_take && cmd_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (wr_en) wr_ptr_q <= !wr_ptr_q;
			if (rd_en) rd_ptr_q <= !rd_ptr_q;
			if (wr_en && !rd_en) count_q <= count_q + 2'd1;
			else if (rd_en && !wr_en) count_q <= count_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) slot_q[wr_ptr_q] <= dec;
	end

endmodule

>>> rtl/core/pfb_back.sv
// Back end: key square build, finalize walk and digraph encryption,
// with the cell and position memories and the result register. Depends on pfb_pkg.
module pfb_back #(
	parameter int GRID_SIDE = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  pfb_pkg::cmd_t cmd,
	input  logic          cmd_valid,
	output logic          cmd_take,
	output pfb_pkg::res_t res,
	output logic          res_valid,
	input  logic          res_pop
);
	import pfb_pkg::*;

	localparam int IDX_W      = $clog2(GRID_SIDE);
	localparam int ADDR_W     = 2 * IDX_W;
	localparam int CELL_DEPTH = 1 << ADDR_W;
	localparam int CELL_COUNT = GRID_SIDE * GRID_SIDE;
	localparam int CNT_W      = $clog2(CELL_COUNT + 1);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(GRID_SIDE - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CELL_COUNT);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_FILL = 2'd1;
	localparam logic [1:0] ST_POS  = 2'd2;
	localparam logic [1:0] ST_CELL = 2'd3;

	function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] x);
		return (x == LAST_IDX) ? '0 : x + 1'b1;
	endfunction

	logic [1:0]            state_q, state_d;
	logic [BYTE_COUNT-1:0] used_q;
	logic                  ready_q;
	logic [CNT_W-1:0]      fill_cnt_q;
	logic [IDX_W-1:0]      fill_row_q, fill_col_q;
	logic [BYTE_W-1:0]     walk_q;
	logic                  res_valid_q;
	res_t                  res_q, res_nxt;

	// cells indexed by {row, col}; positions hold {row, col} per byte value
	logic [BYTE_W-1:0] cell_mem [CELL_DEPTH];
	logic [BYTE_W-1:0] cell_rd0_q, cell_rd1_q;
	logic [ADDR_W-1:0] pos_mem [BYTE_COUNT];
	logic [ADDR_W-1:0] pos_rd0_q, pos_rd1_q;

	logic              room, slot_free, start, enc_ok;
	logic              place_en, set_ready, res_load;
	logic [BYTE_W-1:0] place_byte;
	logic [IDX_W-1:0]  r1, c1, r2, c2;
	logic [ADDR_W-1:0] cell_addr0, cell_addr1;

	assign room      = (fill_cnt_q < FULL_CNT);
	assign slot_free = !res_valid_q || res_pop;
	assign start     = (state_q == ST_IDLE) && cmd_valid && slot_free;
	assign cmd_take  = start;
	assign enc_ok    = ready_q && used_q[cmd.byte_a] && used_q[cmd.byte_b];
	assign res       = res_q;
	assign res_valid = res_valid_q;

	// Playfair rule on the two looked-up positions
	assign r1 = pos_rd0_q[ADDR_W-1:IDX_W];
	assign c1 = pos_rd0_q[IDX_W-1:0];
	assign r2 = pos_rd1_q[ADDR_W-1:IDX_W];
	assign c2 = pos_rd1_q[IDX_W-1:0];

	always_comb begin
		priority if (r1 == r2) begin
			cell_addr0 = {r1, wrap_inc(c1)};
			cell_addr1 = {r2, wrap_inc(c2)};
		end else if (c1 == c2) begin
			cell_addr0 = {wrap_inc(r1), c1};
			cell_addr1 = {wrap_inc(r2), c2};
		end else begin
			cell_addr0 = {r1, c2};
			cell_addr1 = {r2, c1};
		end
	end

	always_comb begin
		state_d    = state_q;
		place_en   = 1'b0;
		place_byte = cmd.byte_a;
		set_ready  = 1'b0;
		res_load   = 1'b0;
		res_nxt    = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					unique case (cmd.kind)
						KIND_KEY: begin
							res_load = 1'b1;
							if (ready_q)
								res_nxt.status = STAT_REJECT;
							else if (cmd.key_zero || used_q[cmd.byte_a] || !room)
								res_nxt.status = STAT_IGNORED;
							else
								place_en = 1'b1;
						end
						KIND_FINAL: begin
							if (ready_q) begin
								res_load       = 1'b1;
								res_nxt.status = STAT_REJECT;
							end else begin
								state_d = ST_FILL;
							end
						end
						KIND_ENCRYPT: begin
							if (enc_ok) begin
								state_d = ST_POS;
							end else begin
								res_load       = 1'b1;
								res_nxt.status = STAT_REJECT;
							end
						end
						KIND_BAD: begin
							res_load       = 1'b1;
							res_nxt.status = STAT_REJECT;
						end
					endcase
				end
			end
			ST_FILL: begin
				// one candidate byte per cycle, ascending
				place_byte = walk_q;
				place_en   = !used_q[walk_q] && room;
				if (walk_q == '1) begin
					set_ready = 1'b1;
					res_load  = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			ST_POS: begin
				state_d = ST_CELL;
			end
			ST_CELL: begin
				res_load           = 1'b1;
				res_nxt.first_out  = cell_rd0_q;
				res_nxt.second_out = cell_rd1_q;
				res_nxt.status     = STAT_DONE;
				state_d            = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			used_q      <= '0;
			ready_q     <= 1'b0;
			fill_cnt_q  <= '0;
			fill_row_q  <= '0;
			fill_col_q  <= '0;
			walk_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_FILL) walk_q <= walk_q + 1'b1;
			if (set_ready) ready_q <= 1'b1;
			if (place_en) begin
				used_q[place_byte] <= 1'b1;
				fill_cnt_q         <= fill_cnt_q + 1'b1;
				if (fill_col_q == LAST_IDX) begin
					fill_col_q <= '0;
					fill_row_q <= fill_row_q + 1'b1;
				end else begin
					fill_col_q <= fill_col_q + 1'b1;
				end
			end
			if (res_load) res_valid_q <= 1'b1;
			else if (res_pop) res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) res_q <= res_nxt;
	end

	always_ff @(posedge clk) begin
		if (place_en) cell_mem[{fill_row_q, fill_col_q}] <= place_byte;
		cell_rd0_q <= cell_mem[cell_addr0];
		cell_rd1_q <= cell_mem[cell_addr1];
	end

	always_ff @(posedge clk) begin
		if (place_en) pos_mem[place_byte] <= {fill_row_q, fill_col_q};
		pos_rd0_q <= pos_mem[cmd.byte_a];
		pos_rd1_q <= pos_mem[cmd.byte_b];
	end

endmodule

>>> rtl/core/playfair_byte_cipher.sv
// Result path: key, rejected and bad requests load the result register on acceptance;
// encrypt loads it after the position and cell reads, finalize after its sweep.
// The back end takes no new command while busy: an encrypt passes through position
// read, then cell read, then result; a finalize has a start step, then one byte_used
// check a cycle over all 256 byte values; a waiting result also stalls command acceptance.
// arst_n clears the square state, queue pointers and result valid; the cell and
// position memories are not cleared and are only read once written.
module playfair_byte_cipher #(
	parameter int GRID_SIDE = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [1:0] operation,
	input  logic [7:0] first_byte,
	input  logic [7:0] second_byte,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] first_out,
	output logic [7:0] second_out,
	output logic [1:0] status
);
	import pfb_pkg::*;

	// Request flow: pfb_front decodes each request into a command and parks
	// it in a two-entry queue, so up to two new requests are taken while the back end
	// walks the finalize sweep or a result waits to be popped.
	cmd_t cmd;
	logic cmd_valid;
	logic cmd_take;

	// Result register lives in the back end; empty is its inverted valid.
	res_t res;
	logic res_valid;

	pfb_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.operation   (operation),
		.first_byte  (first_byte),
		.second_byte (second_byte),
		.cmd         (cmd),
		.cmd_valid   (cmd_valid),
		.cmd_take    (cmd_take)
	);

	// Back end: key bytes go straight into the square in row-major order,
	// finalize sweeps all 256 byte values, encrypt looks up both positions
	// and then both cipher cells from two-read-port memories.
	pfb_back #(
		.GRID_SIDE (GRID_SIDE)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.cmd_valid (cmd_valid),
		.cmd_take  (cmd_take),
		.res       (res),
		.res_valid (res_valid),
		.res_pop   (pop)
	);

	assign empty      = !res_valid;
	assign first_out  = res.first_out;
	assign second_out = res.second_out;
	assign status     = res.status;

endmodule

>>> sim/tb_top.sv
// Self-checking testbench for playfair_byte_cipher: builds one keyed square,
// pushes encrypt and misordered requests before and after it and checks every result.
// Depends on pfb_pkg (op and status codes, res_t) and the playfair_byte_cipher RTL.
module tb_top;
	import pfb_pkg::*;

	localparam int SIDE = 16;
	localparam int CELLS = SIDE * SIDE;
	// no name in the package for the fourth op code
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int IDLE_PCT = 13;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       push = 1'b0;
	logic       full;
	logic [1:0] operation = OP_KEY;
	logic [7:0] first_byte = 8'h00;
	logic [7:0] second_byte = 8'h00;
	logic       empty;
	logic       pop = 1'b0;
	logic [7:0] first_out;
	logic [7:0] second_out;
	logic [1:0] status;

	// predicted square and key state
	logic [7:0]  grid_cell [CELLS];
	logic [7:0]  grid_pos [256];
	bit          placed [256];
	int unsigned filled = 0;
	bit          sealed = 1'b0;

	res_t cipher_expect [$];
	int   mismatches = 0;
	bit   no_idle = 1'b0;

	playfair_byte_cipher #(.GRID_SIDE(SIDE)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.operation(operation),
		.first_byte(first_byte),
		.second_byte(second_byte),
		.empty(empty),
		.pop(pop),
		.first_out(first_out),
		.second_out(second_out),
		.status(status)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void place_in_grid(input int unsigned v);
		grid_cell[filled] = v[7:0];
		grid_pos[v] = filled[7:0];
		placed[v] = 1'b1;
		filled++;
	endfunction

	function automatic logic [7:0] grid_at(input int unsigned row, input int unsigned col);
		return grid_cell[(row * SIDE + col) & 8'hFF];
	endfunction

	// next result of the square for one request; updates the predicted state
	function automatic res_t predict_cipher(input logic [1:0] op, input logic [7:0] a,
			input logic [7:0] b);
		res_t r;
		int unsigned r1, c1, r2, c2;
		r = '0;
		r.status = STAT_DONE;
		case (op)
		OP_KEY: begin
			if (sealed)
				r.status = STAT_REJECT;
			else if (a == 8'h00 || placed[a] || filled >= CELLS)
				r.status = STAT_IGNORED;
			else
				place_in_grid(a);
		end
		OP_FINAL: begin
			if (sealed) begin
				r.status = STAT_REJECT;
			end else begin
				for (int v = 0; v < 256 && filled < CELLS; v++)
					if (!placed[v])
						place_in_grid(v);
				sealed = 1'b1;
			end
		end
		OP_ENCRYPT: begin
			if (!sealed || !placed[a] || !placed[b]) begin
				r.status = STAT_REJECT;
			end else begin
				r1 = grid_pos[a] / SIDE;
				c1 = grid_pos[a] % SIDE;
				r2 = grid_pos[b] / SIDE;
				c2 = grid_pos[b] % SIDE;
				if (r1 == r2) begin
					r.first_out = grid_at(r1, (c1 + 1) % SIDE);
					r.second_out = grid_at(r2, (c2 + 1) % SIDE);
				end else if (c1 == c2) begin
					r.first_out = grid_at((r1 + 1) % SIDE, c1);
					r.second_out = grid_at((r2 + 1) % SIDE, c2);
				end else begin
					// rectangle: swap the corners
					r.first_out = grid_at(r1, c2);
					r.second_out = grid_at(r2, c1);
				end
			end
		end
		default: r.status = STAT_REJECT;
		endcase
		return r;
	endfunction

	// One request. Called at a rising edge; returns at the edge that took it.
	// push is left high so back-to-back requests need no second assignment.
	task automatic send_request(input logic [1:0] op, input logic [7:0] a, input logic [7:0] b);
		while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		operation <= op;
		first_byte <= a;
		second_byte <= b;
		do
			@(posedge clk);
		while (full);
		cipher_expect.push_back(predict_cipher(op, a, b));
	endtask

	// hold off new requests until every expected result is back
	task automatic drain_results();
		push <= 1'b0;
		@(posedge clk);
		while (cipher_expect.size() != 0)
			@(posedge clk);
	endtask

	// Result side: check at each taken result, then pick pop for the next cycle.
	always @(posedge clk) begin
		res_t want;
		if (arst_n && pop && !empty) begin
			if (cipher_expect.size() == 0) begin
				$error("result with nothing expected: %0h %0h status %0d",
					first_out, second_out, status);
				mismatches++;
			end else begin
				want = cipher_expect.pop_front();
				if (first_out !== want.first_out) begin
					$error("first_out expected %0h actual %0h", want.first_out, first_out);
					mismatches++;
				end
				if (second_out !== want.second_out) begin
					$error("second_out expected %0h actual %0h", want.second_out, second_out);
					mismatches++;
				end
				if (status !== want.status) begin
					$error("status expected %0d actual %0d", want.status, status);
					mismatches++;
				end
			end
		end
		pop <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
	end

	// encrypt and misordered requests before the square exists
	task automatic test_early_rejects();
		send_request(OP_ENCRYPT, 8'h00, 8'hFF);
		send_request(OP_UNUSED, 8'hFF, 8'h00);
	endtask

	// zero key byte, duplicates, byte extremes
	task automatic test_key_directed();
		send_request(OP_KEY, 8'h00, 8'hFF);
		send_request(OP_KEY, 8'hFF, 8'h00);
		send_request(OP_KEY, 8'h80, 8'h7F);
		send_request(OP_KEY, 8'h01, 8'hAA);
		send_request(OP_KEY, 8'hFF, 8'h55);
		send_request(OP_KEY, 8'h7F, 8'h80);
		send_request(OP_KEY, 8'h01, 8'h01);
	endtask

	// random key bytes, lots of duplicates, a few stray requests
	task automatic test_key_random();
		int pick;
		for (int i = 0; i < 200; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 4)
				send_request(OP_KEY, 8'h00, 8'($urandom));
			else if (pick < 88)
				send_request(OP_KEY, 8'($urandom), 8'($urandom));
			else if (pick < 94)
				send_request(OP_ENCRYPT, 8'($urandom), 8'($urandom));
			else
				send_request(OP_UNUSED, 8'($urandom), 8'($urandom));
		end
	endtask

	// finalize after a full drain, then everything finalize should lock out
	task automatic test_finalize();
		drain_results();
		send_request(OP_FINAL, 8'h00, 8'h00);
		send_request(OP_FINAL, 8'hFF, 8'hFF);
		send_request(OP_KEY, 8'h02, 8'h00);
		send_request(OP_UNUSED, 8'h00, 8'h00);
	endtask

	// byte extremes, row and column wrap, rectangle, doubled byte
	task automatic test_encrypt_directed();
		send_request(OP_ENCRYPT, 8'h00, 8'hFF);
		send_request(OP_ENCRYPT, 8'hFF, 8'h00);
		send_request(OP_ENCRYPT, 8'h00, 8'h00);
		send_request(OP_ENCRYPT, 8'hFF, 8'hFF);
		send_request(OP_ENCRYPT, grid_cell[3 * SIDE + SIDE - 1], grid_cell[3 * SIDE]);
		send_request(OP_ENCRYPT, grid_cell[(SIDE - 1) * SIDE + 7], grid_cell[7]);
		send_request(OP_ENCRYPT, grid_cell[2 * SIDE + 5], grid_cell[9 * SIDE + 12]);
	endtask

	// mostly encrypts aimed at each rule, some noise; one stretch with no idling
	task automatic test_encrypt_random();
		int pick;
		int unsigned row, col;
		for (int i = 0; i < 1230; i++) begin
			no_idle = (i >= 400 && i < 600);
			if (i == 800)
				drain_results();
			pick = $urandom_range(0, 99);
			row = $urandom_range(0, SIDE - 1);
			col = $urandom_range(0, SIDE - 1);
			if (pick < 40)
				send_request(OP_ENCRYPT, 8'($urandom), 8'($urandom));
			else if (pick < 60)
				send_request(OP_ENCRYPT, grid_cell[row * SIDE + col],
					grid_cell[row * SIDE + $urandom_range(0, SIDE - 1)]);
			else if (pick < 80)
				send_request(OP_ENCRYPT, grid_cell[row * SIDE + col],
					grid_cell[$urandom_range(0, SIDE - 1) * SIDE + col]);
			else if (pick < 90)
				send_request(OP_ENCRYPT, grid_cell[row * SIDE + col], grid_cell[row * SIDE + col]);
			else if (pick < 94)
				send_request(OP_UNUSED, 8'($urandom), 8'($urandom));
			else if (pick < 97)
				send_request(OP_KEY, 8'($urandom), 8'($urandom));
			else
				send_request(OP_FINAL, 8'($urandom), 8'($urandom));
		end
		no_idle = 1'b0;
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_early_rejects();
		test_key_directed();
		test_key_random();
		test_finalize();
		test_encrypt_directed();
		test_encrypt_random();
		drain_results();
		// finalize is the slowest request
		repeat (300) @(posedge clk);
		if (mismatches == 0 && cipher_expect.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#5000000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
